// ===== hw/rtl/tgrr_pkg.sv =====
// ----------------------------------------------------------------------------
// tgrr_pkg
// shared constants, types and helpers of the glyph row renderer
// ----------------------------------------------------------------------------
package tgrr_pkg;

    localparam int unsigned FONT_COUNT     = 3;
    localparam int unsigned GLYPH_COUNT    = 95;
    localparam int unsigned MAX_GLYPH_ROWS = 16;
    localparam int unsigned FIRST_CHAR     = 32;
    localparam int unsigned STORE_DEPTH    = FONT_COUNT * GLYPH_COUNT * MAX_GLYPH_ROWS;
    localparam int unsigned ADDR_W         = $clog2(STORE_DEPTH);
    localparam int unsigned ROW_W          = $clog2(MAX_GLYPH_ROWS);
    localparam int unsigned HEIGHT_W       = 5;
    localparam int unsigned CFG_COUNT      = 3;
    localparam int unsigned PADDR_W        = 4;

    typedef logic [HEIGHT_W-1:0] t_height;
    typedef logic [CFG_COUNT-1:0][HEIGHT_W-1:0] t_heights;

    localparam t_heights HEIGHT_RESET = {5'd13, 5'd12, 5'd10};

    typedef enum logic [1:0] {
        REG_FONT0_HEIGHT = 2'd0,
        REG_FONT1_HEIGHT = 2'd1,
        REG_FONT2_HEIGHT = 2'd2
    } t_reg_idx;

    typedef enum logic {
        REQ_RENDER      = 1'b0,
        REQ_GLYPH_WRITE = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_HALF0,
        S_HALF1
    } t_state;

    function automatic logic [15:0] to_rgb565(input logic [31:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

// ===== hw/rtl/tgrr_ram.sv =====
// ----------------------------------------------------------------------------
// tgrr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tgrr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tgrr_engine.sv =====
// ----------------------------------------------------------------------------
// tgrr_engine
// glyph store access and row sequencer, two four-pixel words per glyph row
// ----------------------------------------------------------------------------
module tgrr_engine
    import tgrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_heights    i_heights,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [1:0]  i_font_select,
    input  logic [6:0]  i_char_code,
    input  logic        i_invert,
    input  logic [9:0]  i_x_pos,
    input  logic [9:0]  i_y_pos,
    input  logic [31:0] i_fg_color,
    input  logic [31:0] i_bg_color,
    input  logic [3:0]  i_glyph_row_index,
    input  logic [7:0]  i_glyph_row_bits,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [10:0] o_out_x,
    output logic [10:0] o_out_y,
    output logic [15:0] o_pixel_a,
    output logic [15:0] o_pixel_b,
    output logic [15:0] o_pixel_c,
    output logic [15:0] o_pixel_d,
    output logic        o_last
);

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [ROW_W-1:0]   r_hlast;
    logic [ADDR_W-1:0]  r_base;
    logic               r_blank;
    logic [15:0]        r_on, r_off;
    logic [9:0]         r_x, r_y;

    logic               r_out_valid, n_out_valid;
    logic [10:0]        r_out_x, r_out_y;
    logic [15:0]        r_pix [4];
    logic               r_last;

    logic               accept, font_ok, char_ok, row_ok, wr_ok;
    logic               start, load, emit, emit_last;
    logic [HEIGHT_W-1:0] h_raw, h_sat;
    logic [ADDR_W-1:0]  glyph_idx, base, waddr, raddr;
    logic               we, re;
    logic [7:0]         rdata, bits;
    logic [3:0]         nibble;
    logic [15:0]        fg565, bg565;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    assign font_ok = {1'b0, i_font_select} < 3'(FONT_COUNT);
    assign char_ok = ({1'b0, i_char_code} >= 8'(FIRST_CHAR)) &&
                     ({1'b0, i_char_code} < 8'(FIRST_CHAR + GLYPH_COUNT));
    assign row_ok  = {1'b0, i_glyph_row_index} < 5'(MAX_GLYPH_ROWS);
    assign wr_ok   = font_ok && char_ok && row_ok;

    assign glyph_idx = ADDR_W'(i_font_select) * ADDR_W'(GLYPH_COUNT) +
                       ADDR_W'(i_char_code - 7'(FIRST_CHAR));
    assign base      = glyph_idx * ADDR_W'(MAX_GLYPH_ROWS);
    assign waddr     = base + ADDR_W'(i_glyph_row_index);

    always_comb begin
        unique case (i_font_select)
            2'd0:    h_raw = i_heights[0];
            2'd1:    h_raw = i_heights[1];
            2'd2:    h_raw = i_heights[2];
            default: h_raw = '0;
        endcase
        h_sat = (h_raw > HEIGHT_W'(MAX_GLYPH_ROWS)) ? HEIGHT_W'(MAX_GLYPH_ROWS) : h_raw;
    end

    assign we    = accept && (t_req'(i_req_type) == REQ_GLYPH_WRITE) && wr_ok;
    assign start = accept && (t_req'(i_req_type) == REQ_RENDER) && font_ok && (h_sat != '0);

    assign fg565 = to_rgb565(i_fg_color);
    assign bg565 = to_rgb565(i_bg_color);

    assign load  = !r_out_valid || i_out_ready;
    assign bits  = r_blank ? 8'h00 : rdata;
    assign raddr = r_base + ADDR_W'(n_row);

    tgrr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_glyph_row_bits),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        re        = 1'b0;
        emit      = 1'b0;
        emit_last = 1'b0;
        nibble    = bits[3:0];
        unique case (r_state)
            S_IDLE: begin
                n_row = '0;
                if (start) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                re      = !r_blank;
                n_state = S_HALF0;
            end
            S_HALF0: begin
                if (load) begin
                    emit    = 1'b1;
                    n_state = S_HALF1;
                end
            end
            S_HALF1: begin
                nibble = bits[7:4];
                if (load) begin
                    emit = 1'b1;
                    if (r_row == r_hlast) begin
                        emit_last = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        // prefetch next row while this word loads
                        n_row   = r_row + 1'b1;
                        re      = !r_blank;
                        n_state = S_HALF0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_hlast <= ROW_W'(h_sat - 1'b1);
            r_base  <= base;
            r_blank <= !char_ok;
            r_on    <= i_invert ? bg565 : fg565;
            r_off   <= i_invert ? fg565 : bg565;
            r_x     <= i_x_pos;
            r_y     <= i_y_pos;
        end
        if (emit) begin
            r_out_x <= {1'b0, r_x} + ((r_state == S_HALF1) ? 11'd4 : 11'd0);
            r_out_y <= {1'b0, r_y} + 11'(r_row);
            r_last  <= emit_last;
            for (int k = 0; k < 4; k++) begin
                r_pix[k] <= nibble[k] ? r_on : r_off;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_pixel_a   = r_pix[0];
    assign o_pixel_b   = r_pix[1];
    assign o_pixel_c   = r_pix[2];
    assign o_pixel_d   = r_pix[3];
    assign o_last      = r_last;

    a_write_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == S_IDLE))
        else $error("glyph store written during a render");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        re |-> (raddr < ADDR_W'(STORE_DEPTH)))
        else $error("glyph store read beyond its depth");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_FETCH) |-> (r_row <= r_hlast))
        else $error("row counter passed the glyph height");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_last |=> (r_state == S_IDLE) && r_out_valid && r_last)
        else $error("final word did not end the render");

endmodule

// ===== hw/rtl/text_glyph_row_renderer.sv =====
// ----------------------------------------------------------------------------
// text_glyph_row_renderer
// character generator with a loadable glyph memory and apb height registers
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_ready) takes one word per request: a glyph
// write stores one 8-bit row of a printable character of font 0..2 and gives
// no output; a render word emits each glyph row as two output words (left
// and right four pixels, rgb565), o_last set on the final one.
// a render has an accept step, then a glyph store read step, then gives one
// word per cycle while the output is not stalled, the next row being read
// through the store's read port while the right half loads.
// invalid fonts and zero heights give no output.
// the output word sits in a register; a stall on i_out_ready holds the
// sequencer, and the next input word is taken while the last output waits.
// reset clears the sequencer and output valid and loads heights 10, 12, 13;
// glyph contents are undefined until written, no clearing pass is run.
// heights live at apb byte addresses 0, 4, 8 and saturate at 16 rows.
// ----------------------------------------------------------------------------
module text_glyph_row_renderer
    import tgrr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic [1:0]         i_font_select,
    input  logic [6:0]         i_char_code,
    input  logic               i_invert,
    input  logic [9:0]         i_x_pos,
    input  logic [9:0]         i_y_pos,
    input  logic [31:0]        i_fg_color,
    input  logic [31:0]        i_bg_color,
    input  logic [3:0]         i_glyph_row_index,
    input  logic [7:0]         i_glyph_row_bits,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [10:0]        o_out_x,
    output logic [10:0]        o_out_y,
    output logic [15:0]        o_pixel_a,
    output logic [15:0]        o_pixel_b,
    output logic [15:0]        o_pixel_c,
    output logic [15:0]        o_pixel_d,
    output logic               o_last
);

    t_heights r_heights, n_heights;
    logic     wr_en;
    t_reg_idx reg_idx;
    logic     idx_ok;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign idx_ok  = paddr[3:2] < 2'(CFG_COUNT);

    always_comb begin
        n_heights = r_heights;
        if (wr_en && idx_ok) begin
            n_heights[paddr[3:2]] = pwdata[HEIGHT_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FONT0_HEIGHT: prdata = 32'(r_heights[0]);
            REG_FONT1_HEIGHT: prdata = 32'(r_heights[1]);
            REG_FONT2_HEIGHT: prdata = 32'(r_heights[2]);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heights <= HEIGHT_RESET;
        end else begin
            r_heights <= n_heights;
        end
    end

    tgrr_engine u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_heights         (r_heights),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_font_select     (i_font_select),
        .i_char_code       (i_char_code),
        .i_invert          (i_invert),
        .i_x_pos           (i_x_pos),
        .i_y_pos           (i_y_pos),
        .i_fg_color        (i_fg_color),
        .i_bg_color        (i_bg_color),
        .i_glyph_row_index (i_glyph_row_index),
        .i_glyph_row_bits  (i_glyph_row_bits),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_x           (o_out_x),
        .o_out_y           (o_out_y),
        .o_pixel_a         (o_pixel_a),
        .o_pixel_b         (o_pixel_b),
        .o_pixel_c         (o_pixel_c),
        .o_pixel_d         (o_pixel_d),
        .o_last            (o_last)
    );

endmodule
